// File: hdl/hermite_tension_bias_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Hermite tension/bias interpolator
// Concurrent checks compile in simulation and drop out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HERMITE_TENSION_BIAS_INTERPOLATOR_CORE_MACROS_SVH
`define HERMITE_TENSION_BIAS_INTERPOLATOR_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define HTBI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htbi: same-cycle check failed");

// next-cycle implication
`define HTBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htbi: next-cycle check failed");

`else

`define HTBI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define HTBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/htbi_pkg.sv
// ----------------------------------------------------------------------------
// htbi_pkg
// Widths, constants and types shared by the Hermite interpolator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htbi_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int POS_FRAC  = 16;
  localparam int POS_W     = POS_FRAC + 1;
  localparam int REG_W     = 16;
  localparam int TB_FRAC   = 14;
  localparam int CFG_IDX_W = 2;

  // tangent path widths (all exact)
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int K_W    = REG_W + 1;
  localparam int PROD_W = DIFF_W + K_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int TAN_W  = SUM_W + K_W;

  // tangents carry 2^SCALE_SHIFT, samples get lifted to match
  localparam int SCALE_SHIFT = 2 * TB_FRAC + 1;
  localparam int COEF_W      = 54;

  // Horner accumulator and the slice that enters each multiply
  localparam int ACC_W      = 104;
  localparam int MUL_W      = 88;
  localparam int CHUNK_W    = 30;
  localparam int HI_W       = MUL_W - 2 * CHUNK_W;
  localparam int LO_PROD_W  = CHUNK_W + POS_W;
  localparam int HI_PROD_W  = HI_W + POS_W + 1;

  // final scaling: 3 position fractions plus tangent scale
  localparam int TOTAL = 3 * POS_FRAC + SCALE_SHIFT;
  localparam int Q_W   = ACC_W - TOTAL;

  localparam int COEF_STAGES = 4;

  localparam logic signed [K_W-1:0] K_ONE = K_W'(2 ** TB_FRAC);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic signed [Q_W-1:0]      Q_MAX      = Q_W'(SAMPLE_MAX);
  localparam logic signed [Q_W-1:0]      Q_MIN      = Q_W'(SAMPLE_MIN);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TENSION = CFG_IDX_W'(0),
    CFG_BIAS    = CFG_IDX_W'(1)
  } cfg_idx_e;

  typedef struct packed {
    logic signed [REG_W-1:0] tension;
    logic signed [REG_W-1:0] bias;
  } cfg_t;

  typedef struct packed {
    sample_t y0;
    sample_t y1;
    sample_t y2;
    sample_t y3;
    pos_t    pos;
  } sample_req_t;

  // running Horner value plus the pre-shifted terms still to be added
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] add_a;
    logic signed [ACC_W-1:0] add_b;
    logic signed [ACC_W-1:0] add_c;
    pos_t                    pos;
  } horner_t;

  typedef struct packed {
    sample_t value;
    logic    saturated;
  } result_t;

endpackage

// File: hdl/htbi_stream_ifs.sv
// ----------------------------------------------------------------------------
// htbi stream interfaces
// Valid/ready channels for interpolation requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface htbi_sample_if;
  logic              valid;
  logic              ready;
  htbi_pkg::sample_t sample_before;
  htbi_pkg::sample_t sample_start;
  htbi_pkg::sample_t sample_end;
  htbi_pkg::sample_t sample_after;
  htbi_pkg::pos_t    position;

  modport source (
    output valid, sample_before, sample_start, sample_end, sample_after, position,
    input  ready
  );
  modport sink (
    input  valid, sample_before, sample_start, sample_end, sample_after, position,
    output ready
  );
endinterface

interface htbi_result_if;
  logic              valid;
  logic              ready;
  htbi_pkg::sample_t value;
  logic              saturated;

  modport source (
    output valid, value, saturated,
    input  ready
  );
  modport sink (
    input  valid, value, saturated,
    output ready
  );
endinterface

// File: hdl/htbi_coef.sv
// ----------------------------------------------------------------------------
// htbi_coef
// Four-stage front end: tangents from neighbor differences, then the cubic
// coefficients in powers of position, lined up for Horner evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hermite_tension_bias_interpolator_core_macros.svh"

module htbi_coef (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  htbi_pkg::cfg_t        cfg_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  htbi_pkg::sample_req_t req_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output htbi_pkg::horner_t     horner_o
);

  logic [htbi_pkg::COEF_STAGES-1:0] vld_q;
  logic [htbi_pkg::COEF_STAGES:0]   rdy;

  // stage 0: differences times bias weights
  logic signed [htbi_pkg::DIFF_W-1:0] d10, d21, d32;
  logic signed [htbi_pkg::K_W-1:0]    kp, km;
  logic signed [htbi_pkg::PROD_W-1:0] pr_d [4];
  logic signed [htbi_pkg::PROD_W-1:0] pr_q [4];
  htbi_pkg::sample_t                  y1_s0_q, y2_s0_q;
  htbi_pkg::pos_t                     pos_s0_q;

  // stage 1: bias-weighted sums
  logic signed [htbi_pkg::SUM_W-1:0]  sum0_d, sum1_d, sum0_q, sum1_q;
  htbi_pkg::sample_t                  y1_s1_q, y2_s1_q;
  htbi_pkg::pos_t                     pos_s1_q;

  // stage 2: tension scaling
  logic signed [htbi_pkg::K_W-1:0]    kt;
  logic signed [htbi_pkg::TAN_W-1:0]  tan0_d, tan1_d, tan0_q, tan1_q;
  htbi_pkg::sample_t                  y1_s2_q, y2_s2_q;
  htbi_pkg::pos_t                     pos_s2_q;

  // stage 3: polynomial coefficients
  logic signed [htbi_pkg::COEF_W-1:0] sy1, sy2, dy, t0, t1, c3, c2;
  htbi_pkg::horner_t                  hn_d, hn_q;

  // ready chain, bubbles collapse
  always_comb begin
    rdy[htbi_pkg::COEF_STAGES] = ready_i;
    for (int k = htbi_pkg::COEF_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[htbi_pkg::COEF_STAGES-1];
  assign horner_o = hn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < htbi_pkg::COEF_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0 logic
  always_comb begin
    d10 = htbi_pkg::DIFF_W'(req_i.y1) - htbi_pkg::DIFF_W'(req_i.y0);
    d21 = htbi_pkg::DIFF_W'(req_i.y2) - htbi_pkg::DIFF_W'(req_i.y1);
    d32 = htbi_pkg::DIFF_W'(req_i.y3) - htbi_pkg::DIFF_W'(req_i.y2);
    kp  = htbi_pkg::K_ONE + htbi_pkg::K_W'(cfg_i.bias);
    km  = htbi_pkg::K_ONE - htbi_pkg::K_W'(cfg_i.bias);
    pr_d[0] = htbi_pkg::PROD_W'(d10) * htbi_pkg::PROD_W'(kp);
    pr_d[1] = htbi_pkg::PROD_W'(d21) * htbi_pkg::PROD_W'(km);
    pr_d[2] = htbi_pkg::PROD_W'(d21) * htbi_pkg::PROD_W'(kp);
    pr_d[3] = htbi_pkg::PROD_W'(d32) * htbi_pkg::PROD_W'(km);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pr_q     <= pr_d;
      y1_s0_q  <= req_i.y1;
      y2_s0_q  <= req_i.y2;
      pos_s0_q <= req_i.pos;
    end
  end

  // stage 1 logic
  always_comb begin
    sum0_d = htbi_pkg::SUM_W'(pr_q[0]) + htbi_pkg::SUM_W'(pr_q[1]);
    sum1_d = htbi_pkg::SUM_W'(pr_q[2]) + htbi_pkg::SUM_W'(pr_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sum0_q   <= sum0_d;
      sum1_q   <= sum1_d;
      y1_s1_q  <= y1_s0_q;
      y2_s1_q  <= y2_s0_q;
      pos_s1_q <= pos_s0_q;
    end
  end

  // stage 2 logic: (1 - t) scaling, the 1/2 is folded into SCALE_SHIFT
  always_comb begin
    kt     = htbi_pkg::K_ONE - htbi_pkg::K_W'(cfg_i.tension);
    tan0_d = htbi_pkg::TAN_W'(sum0_q) * htbi_pkg::TAN_W'(kt);
    tan1_d = htbi_pkg::TAN_W'(sum1_q) * htbi_pkg::TAN_W'(kt);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      tan0_q   <= tan0_d;
      tan1_q   <= tan1_d;
      y1_s2_q  <= y1_s1_q;
      y2_s2_q  <= y2_s1_q;
      pos_s2_q <= pos_s1_q;
    end
  end

  // stage 3 logic: c3 p^3 + c2 p^2 + c1 p + c0, lower terms pre-shifted
  always_comb begin
    sy1 = htbi_pkg::COEF_W'(y1_s2_q) <<< htbi_pkg::SCALE_SHIFT;
    sy2 = htbi_pkg::COEF_W'(y2_s2_q) <<< htbi_pkg::SCALE_SHIFT;
    dy  = sy2 - sy1;
    t0  = htbi_pkg::COEF_W'(tan0_q);
    t1  = htbi_pkg::COEF_W'(tan1_q);
    c3  = t0 + t1 - (dy <<< 1);
    c2  = (dy <<< 1) + dy - (t0 <<< 1) - t1;
    hn_d.acc   = htbi_pkg::ACC_W'(c3);
    hn_d.add_a = htbi_pkg::ACC_W'(c2) <<< htbi_pkg::POS_FRAC;
    hn_d.add_b = htbi_pkg::ACC_W'(t0) <<< (2 * htbi_pkg::POS_FRAC);
    hn_d.add_c = htbi_pkg::ACC_W'(sy1) <<< (3 * htbi_pkg::POS_FRAC);
    hn_d.pos   = pos_s2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      hn_q <= hn_d;
    end
  end

  // a held coefficient stage always frees once the output slot is empty
  `HTBI_ASSERT_NEXT(a_coef_fill, clk_i, rst_ni, vld_q[2] && !vld_q[3], vld_q[3])

endmodule

// File: hdl/htbi_horner.sv
// ----------------------------------------------------------------------------
// htbi_horner
// One Horner step, acc * position + next term, in two stages: chunked
// partial products, then a shifted sum with the waiting term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hermite_tension_bias_interpolator_core_macros.svh"

module htbi_horner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  htbi_pkg::horner_t horner_i,
  output logic              valid_o,
  input  logic              ready_i,
  output htbi_pkg::horner_t horner_o
);

  logic [1:0] vld_q;
  logic [2:0] rdy;

  logic [htbi_pkg::CHUNK_W-1:0]          lo_chunk, mid_chunk;
  logic signed [htbi_pkg::HI_W-1:0]      hi_chunk;
  logic signed [htbi_pkg::POS_W:0]       pos_s;
  logic [htbi_pkg::LO_PROD_W-1:0]        plo_d, pmid_d, plo_q, pmid_q;
  logic signed [htbi_pkg::HI_PROD_W-1:0] phi_d, phi_q;
  logic signed [htbi_pkg::ACC_W-1:0]     add_a_q, add_b_q, add_c_q;
  htbi_pkg::pos_t                        pos_q;
  htbi_pkg::horner_t                     hn_d, hn_q;

  // ready chain
  assign rdy[2]   = ready_i;
  assign rdy[1]   = !vld_q[1] || rdy[2];
  assign rdy[0]   = !vld_q[0] || rdy[1];
  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[1];
  assign horner_o = hn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  // partial products: two unsigned low chunks, one signed top chunk
  always_comb begin
    lo_chunk  = horner_i.acc[htbi_pkg::CHUNK_W-1:0];
    mid_chunk = horner_i.acc[2*htbi_pkg::CHUNK_W-1:htbi_pkg::CHUNK_W];
    hi_chunk  = horner_i.acc[htbi_pkg::MUL_W-1:2*htbi_pkg::CHUNK_W];
    pos_s     = {1'b0, horner_i.pos};
    plo_d     = htbi_pkg::LO_PROD_W'(lo_chunk) * htbi_pkg::LO_PROD_W'(horner_i.pos);
    pmid_d    = htbi_pkg::LO_PROD_W'(mid_chunk) * htbi_pkg::LO_PROD_W'(horner_i.pos);
    phi_d     = htbi_pkg::HI_PROD_W'(hi_chunk) * htbi_pkg::HI_PROD_W'(pos_s);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      plo_q   <= plo_d;
      pmid_q  <= pmid_d;
      phi_q   <= phi_d;
      add_a_q <= horner_i.add_a;
      add_b_q <= horner_i.add_b;
      add_c_q <= horner_i.add_c;
      pos_q   <= horner_i.pos;
    end
  end

  // recombine and add the next coefficient; remaining terms move up
  always_comb begin
    hn_d.acc   = (htbi_pkg::ACC_W'(phi_q) <<< (2 * htbi_pkg::CHUNK_W))
               + (htbi_pkg::ACC_W'(pmid_q) << htbi_pkg::CHUNK_W)
               + htbi_pkg::ACC_W'(plo_q)
               + add_a_q;
    hn_d.add_a = add_b_q;
    hn_d.add_b = add_c_q;
    hn_d.add_c = '0;
    hn_d.pos   = pos_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      hn_q <= hn_d;
    end
  end

  // partial products never wait on an empty sum stage
  `HTBI_ASSERT_NEXT(a_horner_fill, clk_i, rst_ni, vld_q[0] && !vld_q[1], vld_q[1])

endmodule

// File: hdl/htbi_round_sat.sv
// ----------------------------------------------------------------------------
// htbi_round_sat
// Output stage: drops the fixed-point scale with round-half-up, clamps to
// the sample range and flags clamping. Holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hermite_tension_bias_interpolator_core_macros.svh"

module htbi_round_sat (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  htbi_pkg::horner_t horner_i,
  output logic              valid_o,
  input  logic              ready_i,
  output htbi_pkg::result_t result_o
);

  logic                          vld_q;
  logic signed [htbi_pkg::Q_W-1:0] q_floor, q_rnd;
  logic                          over, under;
  htbi_pkg::result_t             res_d, res_q;

  assign ready_o  = !vld_q || ready_i;
  assign valid_o  = vld_q;
  assign result_o = res_q;

  // rounding: floor of the scaled value plus the first dropped bit
  always_comb begin
    q_floor = horner_i.acc[htbi_pkg::ACC_W-1:htbi_pkg::TOTAL];
    q_rnd   = q_floor + htbi_pkg::Q_W'(horner_i.acc[htbi_pkg::TOTAL-1]);
    over    = q_rnd > htbi_pkg::Q_MAX;
    under   = q_rnd < htbi_pkg::Q_MIN;
    res_d.saturated = over || under;
    if (over) begin
      res_d.value = htbi_pkg::SAMPLE_MAX;
    end else if (under) begin
      res_d.value = htbi_pkg::SAMPLE_MIN;
    end else begin
      res_d.value = q_rnd[htbi_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      res_q <= res_d;
    end
  end

  // a flagged result sits on one of the rails
  `HTBI_ASSERT_IMPLY(a_sat_rail, clk_i, rst_ni, vld_q && res_q.saturated, (res_q.value == htbi_pkg::SAMPLE_MAX) || (res_q.value == htbi_pkg::SAMPLE_MIN))

endmodule

// File: hdl/hermite_tension_bias_interpolator_core.sv
// ----------------------------------------------------------------------------
// hermite_tension_bias_interpolator_core
// Cubic Hermite interpolator with tension and bias, exact fixed point,
// rounded and saturated to 16 bits.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+--------------------------------------
//  sample_i  | in  | valid / ready    | four samples, position (Q1.16)
//  result_o  | out | valid / ready    | value, saturated
//  cfg_*     | in  | write enable     | register index, 16-bit data
//
//  One request enters per cycle while results are taken; the pipe holds 4
//  coefficient stages, three Horner steps of 2 stages each (chunked position
//  multiply, then sum), and the round/saturate result register.
//  Reset clears the valid bits and the tension and bias registers.
//  A stalled result holds the last stage only; empty stages upstream keep
//  filling, so requests are taken until every stage holds one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hermite_tension_bias_interpolator_core_macros.svh"

module hermite_tension_bias_interpolator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [htbi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [htbi_pkg::REG_W-1:0]      cfg_wdata_i,
  htbi_sample_if.sink                     sample_i,
  htbi_result_if.source                   result_o
);

  htbi_pkg::cfg_t        cfg_q;
  htbi_pkg::sample_req_t req;
  htbi_pkg::horner_t     hn [4];
  htbi_pkg::result_t     res;
  logic [3:0]            hn_vld;
  logic [3:0]            hn_rdy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (htbi_pkg::cfg_idx_e'(cfg_idx_i))
        htbi_pkg::CFG_TENSION: cfg_q.tension <= cfg_wdata_i;
        htbi_pkg::CFG_BIAS:    cfg_q.bias    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request payload
  always_comb begin
    req.y0  = sample_i.sample_before;
    req.y1  = sample_i.sample_start;
    req.y2  = sample_i.sample_end;
    req.y3  = sample_i.sample_after;
    req.pos = sample_i.position;
  end

  htbi_coef u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (sample_i.valid),
    .ready_o  (sample_i.ready),
    .req_i    (req),
    .valid_o  (hn_vld[0]),
    .ready_i  (hn_rdy[0]),
    .horner_o (hn[0])
  );

  // p^2 term, p term, constant term
  htbi_horner u_horner_0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (hn_vld[0]),
    .ready_o  (hn_rdy[0]),
    .horner_i (hn[0]),
    .valid_o  (hn_vld[1]),
    .ready_i  (hn_rdy[1]),
    .horner_o (hn[1])
  );

  htbi_horner u_horner_1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (hn_vld[1]),
    .ready_o  (hn_rdy[1]),
    .horner_i (hn[1]),
    .valid_o  (hn_vld[2]),
    .ready_i  (hn_rdy[2]),
    .horner_o (hn[2])
  );

  htbi_horner u_horner_2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (hn_vld[2]),
    .ready_o  (hn_rdy[2]),
    .horner_i (hn[2]),
    .valid_o  (hn_vld[3]),
    .ready_i  (hn_rdy[3]),
    .horner_o (hn[3])
  );

  htbi_round_sat u_round_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (hn_vld[3]),
    .ready_o  (hn_rdy[3]),
    .horner_i (hn[3]),
    .valid_o  (result_o.valid),
    .ready_i  (result_o.ready),
    .result_o (res)
  );

  assign result_o.value     = res.value;
  assign result_o.saturated = res.saturated;

  // with the result slot free the whole pipe can shift, so requests flow
  `HTBI_ASSERT_IMPLY(a_top_ready, clk_i, rst_ni, !result_o.valid || result_o.ready, sample_i.ready)

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: Hermite tension/bias interpolator testbench
// A directed list of requests covers the sample and position extremes, the
// tie rounding, saturation both ways, extrapolation past one and tension/bias
// settings outside +/-1. Random phases at several register settings follow.
// Each result is checked against a fixed value or a bit-exact wide-integer
// predictor, with random idle gaps on requests and random stalls on results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import htbi_pkg::*;

  localparam int     CYCLE_LIMIT     = 600_000;
  localparam int     ITEMS_PER_PHASE = 225;
  localparam int     RANDOM_PHASES   = 6;
  localparam int     TAIL_CYCLES     = 20;
  localparam int     EXACT_W         = 160;

  // register indexes that map to nothing in the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  localparam pos_t POS_ZERO = '0;
  localparam pos_t POS_HALF = pos_t'(1 << (POS_FRAC - 1));
  localparam pos_t POS_ONE  = pos_t'(1 << POS_FRAC);
  localparam pos_t POS_MAX  = '1;

  localparam logic signed [REG_W-1:0] Q14_ONE     = REG_W'(1 << TB_FRAC);
  localparam logic signed [REG_W-1:0] Q14_NEG_ONE = -Q14_ONE;

  typedef logic signed [EXACT_W-1:0] exact_t;
  localparam exact_t EXACT_ONE = exact_t'(1);

  typedef enum int {SHAPE_FULL, SHAPE_RAIL, SHAPE_SMOOTH, SHAPE_SMALL} shape_e;

  typedef struct {
    logic signed [REG_W-1:0] tension;
    logic signed [REG_W-1:0] bias;
    sample_req_t             req;
    bit                      fixed_known;
    result_t                 fixed_res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;

  htbi_sample_if sample_if ();
  htbi_result_if result_if ();

  hermite_tension_bias_interpolator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  // interpolated results still owed by the block, oldest first
  result_t                 pending_results[$];
  dir_row_t                directed_rows[$];
  logic signed [REG_W-1:0] cur_tension = '0;
  logic signed [REG_W-1:0] cur_bias = '0;

  int  cycle_count = 0;
  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_checked = 0;
  int  saturated_seen = 0;
  int  settings_used = 1;
  int  stall_left = 0;
  bit  sender_calm = 1'b0;
  bit  sink_calm = 1'b0;
  bit  spare_toggle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Exact cubic Hermite sum, rounded half up, saturated to the sample range
  function automatic result_t interp_expect(input sample_req_t req,
                                            input logic signed [REG_W-1:0] ten,
                                            input logic signed [REG_W-1:0] bia);
    exact_t  w0, w1, w2, w3, p, pf, kt, kp, km, m0, m1;
    exact_t  p2, p3, p2f, pf2, f3, a0, a1, a2, a3, acc, q;
    result_t r;
    w0 = exact_t'(req.y0);
    w1 = exact_t'(req.y1);
    w2 = exact_t'(req.y2);
    w3 = exact_t'(req.y3);
    p  = exact_t'(req.pos);
    pf = EXACT_ONE <<< POS_FRAC;
    kt = exact_t'(ten);
    kt = (EXACT_ONE <<< TB_FRAC) - kt;
    kp = exact_t'(bia);
    km = (EXACT_ONE <<< TB_FRAC) - kp;
    kp = (EXACT_ONE <<< TB_FRAC) + kp;
    // tangents carry 2^(2*TB_FRAC+1)
    m0 = ((w1 - w0) * kp + (w2 - w1) * km) * kt;
    m1 = ((w2 - w1) * kp + (w3 - w2) * km) * kt;
    // basis polynomials carry 2^(3*POS_FRAC)
    p2  = p * p;
    p3  = p2 * p;
    p2f = p2 * pf;
    pf2 = p * pf * pf;
    f3  = pf * pf * pf;
    a0  = 2 * p3 - 3 * p2f + f3;
    a1  = p3 - 2 * p2f + pf2;
    a2  = p3 - p2f;
    a3  = 3 * p2f - 2 * p3;
    acc = ((a0 * w1 + a3 * w2) <<< SCALE_SHIFT) + a1 * m0 + a2 * m1
          + (EXACT_ONE <<< (TOTAL - 1));
    q   = acc >>> TOTAL;
    r.saturated = 1'b0;
    if (q > SAMPLE_MAX) begin
      q = exact_t'(SAMPLE_MAX);
      r.saturated = 1'b1;
    end else if (q < SAMPLE_MIN) begin
      q = exact_t'(SAMPLE_MIN);
      r.saturated = 1'b1;
    end
    r.value = q[SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic add_row(input int t, input int b, input int y0, input int y1,
                         input int y2, input int y3, input pos_t pos,
                         input bit known, input int want, input bit want_sat);
    dir_row_t row;
    row.tension               = REG_W'(t);
    row.bias                  = REG_W'(b);
    row.req.y0                = sample_t'(y0);
    row.req.y1                = sample_t'(y1);
    row.req.y2                = sample_t'(y2);
    row.req.y3                = sample_t'(y3);
    row.req.pos               = pos;
    row.fixed_known           = known;
    row.fixed_res.value       = sample_t'(want);
    row.fixed_res.saturated   = want_sat;
    directed_rows.push_back(row);
  endtask

  // Hold off new requests until every owed result has come back
  task automatic drain_results();
    sample_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Both registers back to back, then a write to an unmapped index
  task automatic program_regs(input logic signed [REG_W-1:0] ten,
                              input logic signed [REG_W-1:0] bia);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TENSION;
    cfg_wdata_i <= ten;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BIAS;
    cfg_wdata_i <= bia;
    @(posedge clk_i);
    cfg_idx_i   <= spare_toggle ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_wdata_i <= REG_W'($urandom);
    spare_toggle = !spare_toggle;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_tension = ten;
    cur_bias    = bia;
    settings_used++;
  endtask

  task automatic send_request(input sample_req_t req, input bit known,
                              input result_t fixed_res);
    sample_if.valid         <= 1'b1;
    sample_if.sample_before <= req.y0;
    sample_if.sample_start  <= req.y1;
    sample_if.sample_end    <= req.y2;
    sample_if.sample_after  <= req.y3;
    sample_if.position      <= req.pos;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    if (known) pending_results.push_back(fixed_res);
    else pending_results.push_back(interp_expect(req, cur_tension, cur_bias));
    requests_sent++;
  endtask

  // Idle gap after a request: mostly none or short, a few long
  task automatic pace_sender();
    int gap;
    int roll;
    if (requests_sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (!sender_calm) begin
      if (roll >= 90) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic sample_t rail_sample();
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic sample_req_t random_request();
    sample_req_t req;
    shape_e      shape;
    int          roll;
    int          base;
    int          step;
    roll = $urandom_range(0, 99);
    if (roll < 40) shape = SHAPE_FULL;
    else if (roll < 55) shape = SHAPE_RAIL;
    else if (roll < 85) shape = SHAPE_SMOOTH;
    else shape = SHAPE_SMALL;
    case (shape)
      SHAPE_FULL: begin
        req.y0 = sample_t'($urandom);
        req.y1 = sample_t'($urandom);
        req.y2 = sample_t'($urandom);
        req.y3 = sample_t'($urandom);
      end
      SHAPE_RAIL: begin
        req.y0 = rail_sample();
        req.y1 = rail_sample();
        req.y2 = rail_sample();
        req.y3 = rail_sample();
      end
      SHAPE_SMOOTH: begin
        // a slowly moving signal with a little noise on each sample
        base   = $urandom_range(0, 60000) - 30000;
        step   = $urandom_range(0, 1000) - 500;
        req.y0 = sample_t'(base + $urandom_range(0, 64) - 32);
        req.y1 = sample_t'(base + step + $urandom_range(0, 64) - 32);
        req.y2 = sample_t'(base + 2 * step + $urandom_range(0, 64) - 32);
        req.y3 = sample_t'(base + 3 * step + $urandom_range(0, 64) - 32);
      end
      default: begin
        req.y0 = sample_t'($urandom_range(0, 511) - 256);
        req.y1 = sample_t'($urandom_range(0, 511) - 256);
        req.y2 = sample_t'($urandom_range(0, 511) - 256);
        req.y3 = sample_t'($urandom_range(0, 511) - 256);
      end
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0:       req.pos = POS_ZERO;
        1:       req.pos = pos_t'(1);
        2:       req.pos = POS_ONE - pos_t'(1);
        default: req.pos = POS_ONE;
      endcase
    end else if (roll == 1) begin
      // past one: the block extrapolates
      req.pos = pos_t'($urandom_range(int'(POS_ONE) + 1, int'(POS_MAX)));
    end else begin
      req.pos = pos_t'($urandom_range(0, int'(POS_ONE)));
    end
    return req;
  endfunction

  function automatic logic signed [REG_W-1:0] random_q14();
    return REG_W'($urandom_range(0, 2 * int'(Q14_ONE)) - int'(Q14_ONE));
  endfunction

  // Result side: compare on handshake, then pick next ready
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d saturated=%0b", $time,
                   result_if.value, result_if.saturated);
          mismatches++;
        end else begin
          result_t want;
          want = pending_results.pop_front();
          if (result_if.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     want.value, result_if.value);
            mismatches++;
          end
          if (result_if.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
                     want.saturated, result_if.saturated);
            mismatches++;
          end
          if (want.saturated) saturated_seen++;
          results_checked++;
        end
      end
      if (cycle_count % 256 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Request side and phase sequencing
  initial begin
    logic signed [REG_W-1:0] ten;
    logic signed [REG_W-1:0] bia;
    result_t                 no_fixed;
    no_fixed = '0;

    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CFG_TENSION;
    cfg_wdata_i             <= '0;
    sample_if.valid         <= 1'b0;
    sample_if.sample_before <= '0;
    sample_if.sample_start  <= '0;
    sample_if.sample_end    <= '0;
    sample_if.sample_after  <= '0;
    sample_if.position      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: Catmull-Rom
    add_row(0, 0, 0, 0, 0, 0, POS_ZERO, 1, 0, 0);
    add_row(0, 0, -5, 32767, 100, 7, POS_ZERO, 1, 32767, 0);
    add_row(0, 0, 9, -32768, -3, 4, POS_ZERO, 1, -32768, 0);
    add_row(0, 0, 1, 2, -32768, 5, POS_ONE, 1, -32768, 0);
    // exact half lands on zero: ties go up
    add_row(0, 0, -32768, -32768, 32767, 32767, POS_HALF, 1, 0, 0);
    // overshoot past both rails
    add_row(0, 0, -32768, 32767, 32767, -32768, POS_HALF, 1, 32767, 1);
    add_row(0, 0, 32767, -32768, -32768, 32767, POS_HALF, 1, -32768, 1);
    add_row(0, 0, 1234, 1234, 1234, 1234, pos_t'(40000), 1, 1234, 0);
    add_row(0, 0, 100, -200, 3000, -4000, pos_t'(1), 0, 0, 0);
    add_row(0, 0, 100, -200, 3000, -4000, POS_ONE - pos_t'(1), 0, 0, 0);
    // extrapolation past the end of the interval
    add_row(0, 0, 0, 0, 1000, 2000, POS_MAX, 0, 0, 0);
    add_row(0, 0, -32768, 0, 32767, -32768, POS_MAX, 0, 0, 0);
    // tight: zero tangents
    add_row(16384, 0, -1000, 0, 1000, -3000, pos_t'(20000), 0, 0, 0);
    // loose with full positive bias, then full negative bias alone
    add_row(-16384, 16384, 32767, -32768, 32767, -32768, pos_t'(16384), 0, 0, 0);
    add_row(-16384, 16384, -32768, 32767, -32768, 32767, pos_t'(49152), 0, 0, 0);
    add_row(0, -16384, 5, -7, 11, -13, pos_t'(12345), 0, 0, 0);
    add_row(0, -16384, -1, -32768, 32767, -1, POS_HALF, 0, 0, 0);
    // register values beyond one are used unclamped
    add_row(32767, -32768, 30000, -30000, 30000, -30000, POS_HALF, 0, 0, 0);
    add_row(32767, -32768, 777, 777, 777, 777, pos_t'(54321), 1, 777, 0);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767, POS_ONE, 1, -32768, 0);
    add_row(-32768, 32767, -32768, 32767, -32768, 32767, pos_t'(98304), 0, 0, 0);
    add_row(-32768, 32767, 0, 32767, 0, 0, POS_ZERO, 1, 32767, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].tension !== cur_tension || directed_rows[i].bias !== cur_bias) begin
        drain_results();
        program_regs(directed_rows[i].tension, directed_rows[i].bias);
      end
      send_request(directed_rows[i].req, directed_rows[i].fixed_known,
                   directed_rows[i].fixed_res);
      pace_sender();
    end

    // random phases, each at its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin ten = Q14_ONE;     bia = Q14_ONE;     end
        1: begin ten = Q14_NEG_ONE; bia = Q14_NEG_ONE; end
        2: begin ten = '0;          bia = '0;          end
        3: begin ten = REG_W'($urandom); bia = REG_W'($urandom); end
        default: begin ten = random_q14(); bia = random_q14(); end
      endcase
      drain_results();
      program_regs(ten, bia);
      repeat (ITEMS_PER_PHASE) begin
        send_request(random_request(), 1'b0, no_fixed);
        pace_sender();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests over %0d register settings, %0d results checked",
             requests_sent, settings_used, results_checked);
    $display("%0d results clipped at a rail, %0d mismatches", saturated_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/htbi_pkg.sv
hdl/htbi_stream_ifs.sv
hdl/htbi_coef.sv
hdl/htbi_horner.sv
hdl/htbi_round_sat.sv
hdl/hermite_tension_bias_interpolator_core.sv
bench/tb.sv
